[rtl/core/ptgi_pkg.sv]
// ----------------------------------------------------------------------------
// ptgi_pkg
// Shared types and constants of the periodic trilinear grid interpolator.
// ----------------------------------------------------------------------------
package ptgi_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 3'd7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // width of the value fed through the remainder unit, and of its step counter
    localparam int DVD_W = 33;
    localparam int CNT_W = 6;

    localparam logic [16:0] W_ONE = 17'h10000;

    typedef struct packed {
        logic               action;
        logic [14:0]        cell_address;
        logic [15:0]        cell_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic [15:0] density;
        logic        over_limit;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AX_SUB,
        ST_AX_MUL,
        ST_AX_PREP,
        ST_AX_MOD,
        ST_AX_FIN,
        ST_CN_ADDR,
        ST_CN_MOD,
        ST_CN_READ,
        ST_CN_MUL2,
        ST_CN_MUL3,
        ST_CN_ACC,
        ST_DONE
    } state_t;

endpackage

[rtl/core/ptgi_ram.sv]
// ----------------------------------------------------------------------------
// ptgi_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptgi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/periodic_trilinear_grid_interp_core.sv]
// ----------------------------------------------------------------------------
// periodic_trilinear_grid_interp_core
// Periodic 3D grid store with trilinear interpolation of Q16.16 queries.
// ----------------------------------------------------------------------------
// A grid write word is written to the grid as it is taken. A query word runs
// the three axes and then the eight corners; when DIM_MAX**3 > GRID_CELLS each
// corner also passes the wrap state ST_CN_MOD. One item is worked on at a time;
// the bit-serial remainder unit and the corner reads of the single grid port
// set how long a query takes. A finished result waits in an output register
// while the next word is taken. Reset (aresetn low, synchronous) clears control
// state and the configuration registers; grid contents are undefined until written.
module periodic_trilinear_grid_interp_core
    import ptgi_pkg::*;
#(
    parameter int GRID_CELLS = 32768,
    parameter int DIM_MAX    = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int  AW        = $clog2(GRID_CELLS);
    localparam int  NW        = $clog2(DIM_MAX + 1);   // axis size
    localparam int  CW        = $clog2(DIM_MAX);       // cell index
    localparam int  SW        = $clog2(DIM_MAX * DIM_MAX * DIM_MAX);
    localparam bit  NEED_WRAP = (DIM_MAX * DIM_MAX * DIM_MAX) > GRID_CELLS;
    localparam int  DVW       = (NW > AW + 1) ? NW : AW + 1;
    localparam int  QW        = 2 * SW;
    // reciprocal of the grid depth for the corner address wrap
    localparam logic [SW-1:0] ADDR_RCP = SW'((64'd1 << SW) / 64'(GRID_CELLS));
    localparam logic [SW-1:0] CELLS_SW = SW'(GRID_CELLS);

    // configuration
    logic [31:0] org_reg [3];
    logic [31:0] inv_step_reg;
    logic [5:0]  size_reg [3];
    logic [15:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0]   <= '0;
            org_reg[1]   <= '0;
            org_reg[2]   <= '0;
            inv_step_reg <= 32'd65536;
            size_reg[0]  <= 6'd32;
            size_reg[1]  <= 6'd32;
            size_reg[2]  <= 6'd32;
            limit_reg    <= 16'hFFFF;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ORIGIN_X:    org_reg[0]   <= cfg_wdata;
                CFG_ORIGIN_Y:    org_reg[1]   <= cfg_wdata;
                CFG_ORIGIN_Z:    org_reg[2]   <= cfg_wdata;
                CFG_INV_STEP:    inv_step_reg <= cfg_wdata;
                CFG_SIZE_X:      size_reg[0]  <= cfg_wdata[5:0];
                CFG_SIZE_Y:      size_reg[1]  <= cfg_wdata[5:0];
                CFG_SIZE_Z:      size_reg[2]  <= cfg_wdata[5:0];
                CFG_VALUE_LIMIT: limit_reg    <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Clamp a size register: zero acts as one, anything above DIM_MAX saturates.
    function automatic logic [NW-1:0] eff_size(input logic [5:0] s);
        logic [NW-1:0] r;
        if (s == 6'd0) begin
            r = NW'(1);
        end else if (int'(s) > DIM_MAX) begin
            r = NW'(DIM_MAX);
        end else begin
            r = NW'(s);
        end
        return r;
    endfunction

    logic [NW-1:0] n_size [3];
    assign n_size[0] = eff_size(size_reg[0]);
    assign n_size[1] = eff_size(size_reg[1]);
    assign n_size[2] = eff_size(size_reg[2]);

    // sequencer state and datapath registers
    state_t state_reg, state_next;

    logic [31:0]      pos_reg [3];
    logic [2*NW-1:0]  nyz_reg;
    logic [1:0]       ax_reg;
    logic             neg_reg;
    logic [31:0]      mag_reg;
    logic [63:0]      prod_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVW-1:0]   rem_reg;
    logic [DVW-1:0]   div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CW-1:0]    lo_reg   [3];
    logic [CW-1:0]    hi_reg   [3];
    logic [15:0]      frac_reg [3];
    logic [2:0]       corner_reg;
    logic [33:0]      w1_reg;
    logic [48:0]      w2_reg;
    logic [63:0]      term_reg;
    logic [63:0]      acc_reg;
    logic             m_valid_reg;
    out_word_t        m_data_reg;

    // control outputs of the sequencer
    typedef struct packed {
        logic s_ready;
        logic ram_we;
        logic ram_re;
        logic done_fire;
    } ctl_t;
    ctl_t ctl;

    logic            s_fire;
    logic            mod_last;
    logic [DVW:0]    trial;
    logic [AW-1:0]   ram_addr;
    logic [15:0]     ram_rdata;

    assign s_fire   = s_valid && ctl.s_ready;
    assign mod_last = (cnt_reg == CNT_W'(DVD_W - 1));
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.action == ACT_QUERY) begin
                    state_next = ST_AX_SUB;
                end
            end
            ST_AX_SUB:  state_next = ST_AX_MUL;
            ST_AX_MUL:  state_next = ST_AX_PREP;
            ST_AX_PREP: state_next = ST_AX_MOD;
            ST_AX_MOD: begin
                if (mod_last) begin
                    state_next = ST_AX_FIN;
                end
            end
            ST_AX_FIN: begin
                state_next = (ax_reg == 2'd2) ? ST_CN_ADDR : ST_AX_SUB;
            end
            ST_CN_ADDR: state_next = NEED_WRAP ? ST_CN_MOD : ST_CN_READ;
            ST_CN_MOD:  state_next = ST_CN_READ;
            ST_CN_READ: state_next = ST_CN_MUL2;
            ST_CN_MUL2: state_next = ST_CN_MUL3;
            ST_CN_MUL3: state_next = ST_CN_ACC;
            ST_CN_ACC: begin
                state_next = (corner_reg == 3'd7) ? ST_DONE : ST_CN_ADDR;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctl           = '0;
        ctl.s_ready   = (state_reg == ST_IDLE);
        ctl.ram_we    = (state_reg == ST_IDLE) && s_valid
                        && (s_data.action == ACT_WRITE)
                        && (32'(s_data.cell_address) < 32'(GRID_CELLS));
        ctl.ram_re    = (state_reg == ST_CN_READ);
        ctl.done_fire = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // corner selection: bit 2 picks x, bit 1 y, bit 0 z
    logic [CW-1:0] cx, cy, cz;
    logic [16:0]   wx, wy, wz;
    logic [SW-1:0] lin_addr;

    assign cx = corner_reg[2] ? hi_reg[0] : lo_reg[0];
    assign cy = corner_reg[1] ? hi_reg[1] : lo_reg[1];
    assign cz = corner_reg[0] ? hi_reg[2] : lo_reg[2];
    assign wx = corner_reg[2] ? {1'b0, frac_reg[0]} : W_ONE - {1'b0, frac_reg[0]};
    assign wy = corner_reg[1] ? {1'b0, frac_reg[1]} : W_ONE - {1'b0, frac_reg[1]};
    assign wz = corner_reg[0] ? {1'b0, frac_reg[2]} : W_ONE - {1'b0, frac_reg[2]};
    assign lin_addr = SW'(cx) * SW'(nyz_reg) + SW'(cy) * SW'(n_size[2]) + SW'(cz);

    // Corner wrap: the reciprocal estimate of the quotient is short by at most
    // one, so a single compare and subtract finishes the remainder.
    logic [QW-1:0] q_prod;
    logic [SW-1:0] q_est;
    logic [SW-1:0] r_est;

    assign q_prod = QW'(dvd_reg[SW-1:0]) * QW'(ADDR_RCP);
    assign q_est  = q_prod[QW-1:SW];
    assign r_est  = dvd_reg[SW-1:0] - SW'(QW'(q_est) * QW'(CELLS_SW));

    // Grid address: the cell address for a write; for a read, the remainder when wrapping, else the linear sum as is.
    assign ram_addr = ctl.ram_we ? AW'(s_data.cell_address)
                    : (NEED_WRAP ? AW'(rem_reg) : AW'(dvd_reg));

    // axis arithmetic
    logic [32:0] d_ax;
    logic [48:0] t_ax;
    logic [49:0] c_ax;
    logic [NW-1:0] n_ax;
    logic [CW-1:0] cell_ax;
    logic [NW-1:0] cell_up;

    assign n_ax = n_size[ax_reg];
    assign d_ax = {pos_reg[ax_reg][31], pos_reg[ax_reg]}
                - {org_reg[ax_reg][31], org_reg[ax_reg]};
    // magnitude in Q32.16 rounded up, then minus the floor of the coordinate
    assign t_ax = {1'b0, prod_reg[63:16]} + 49'(|prod_reg[15:0]);
    assign c_ax = ({1'b0, t_ax} + 50'h0FFFF) >> 16;

    always_comb begin
        if (!neg_reg) begin
            cell_ax = CW'(rem_reg);
        end else if (rem_reg == '0) begin
            cell_ax = '0;
        end else begin
            cell_ax = CW'(n_ax - NW'(rem_reg));
        end
        cell_up = NW'(cell_ax) + NW'(1);
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.action == ACT_QUERY) begin
                    pos_reg[0] <= s_data.pos_x;
                    pos_reg[1] <= s_data.pos_y;
                    pos_reg[2] <= s_data.pos_z;
                    nyz_reg    <= (2*NW)'(n_size[1]) * (2*NW)'(n_size[2]);
                    ax_reg     <= 2'd0;
                end
            end
            ST_AX_SUB: begin
                neg_reg <= d_ax[32];
                mag_reg <= d_ax[32] ? 32'(-d_ax) : d_ax[31:0];
            end
            ST_AX_MUL: begin
                prod_reg <= 64'(mag_reg) * 64'(inv_step_reg);
            end
            ST_AX_PREP: begin
                if (!neg_reg) begin
                    dvd_reg          <= {1'b0, prod_reg[63:32]};
                    frac_reg[ax_reg] <= prod_reg[31:16];
                end else begin
                    dvd_reg          <= c_ax[DVD_W-1:0];
                    frac_reg[ax_reg] <= 16'(16'h0 - t_ax[15:0]);
                end
                div_reg <= DVW'(n_ax);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_AX_MOD: begin
                // one restoring step: shift in a bit, subtract when it fits
                if (trial >= {1'b0, div_reg}) begin
                    rem_reg <= DVW'(trial - {1'b0, div_reg});
                end else begin
                    rem_reg <= trial[DVW-1:0];
                end
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_CN_MOD: begin
                rem_reg <= (r_est >= CELLS_SW) ? DVW'(r_est - CELLS_SW) : DVW'(r_est);
            end
            ST_AX_FIN: begin
                lo_reg[ax_reg] <= cell_ax;
                hi_reg[ax_reg] <= (cell_up == n_ax) ? '0 : CW'(cell_up);
                ax_reg         <= ax_reg + 2'd1;
                corner_reg     <= '0;
                acc_reg        <= '0;
            end
            ST_CN_ADDR: begin
                dvd_reg <= DVD_W'(lin_addr);
            end
            ST_CN_READ: begin
                w1_reg <= 34'(wx) * 34'(wy);
            end
            ST_CN_MUL2: begin
                w2_reg <= 49'(51'(w1_reg) * 51'(wz));
            end
            ST_CN_MUL3: begin
                term_reg <= 64'(w2_reg) * 64'(ram_rdata);
            end
            ST_CN_ACC: begin
                acc_reg    <= acc_reg + term_reg;
                corner_reg <= corner_reg + 3'd1;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // result register: holds one word while the next item is taken
    logic [63:0] rounded;
    assign rounded = acc_reg + 64'h0000_8000_0000_0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.done_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.done_fire) begin
            m_data_reg.density    <= rounded[63:48];
            m_data_reg.over_limit <= (rounded[63:48] > limit_reg);
        end
    end

    ptgi_ram #(
        .WIDTH (16),
        .DEPTH (GRID_CELLS)
    ) u_grid (
        .aclk  (aclk),
        .we    (ctl.ram_we),
        .re    (ctl.ram_re),
        .addr  (ram_addr),
        .wdata (s_data.cell_value),
        .rdata (ram_rdata)
    );

    assign s_ready = ctl.s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/core/ptgi_checker.sv]
// ----------------------------------------------------------------------------
// ptgi_checker
// Port-level assertions for the periodic trilinear grid interpolator.
// ----------------------------------------------------------------------------
module ptgi_checker
    import ptgi_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a query occupies the block: no word is taken in the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_QUERY |=> !s_ready)
        else $error("input taken right after a query");

    // a result appears as the block goes back to idle
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result appeared while busy");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind periodic_trilinear_grid_interp_core ptgi_checker u_ptgi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
